@@ hdl/tlpt_pkg.sv @@
package tlpt_pkg;

    localparam int NUM_TABLES_DEFAULT = 16;

    localparam int DIR_ENTRIES = 1024;
    localparam int TBL_ENTRIES = 1024;
    localparam int IDX_W       = 10;
    localparam int OFFSET_W    = 12;
    localparam int VPN_W       = 20;
    localparam int ADDR_W      = 32;
    localparam int ENTRY_W     = 32;

    localparam int FLAG_PRESENT_BIT = 0;
    localparam int FLAG_USER_BIT    = 2;

    localparam logic [VPN_W-1:0] RESERVED_RESET = 20'd1023;

    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_UNMAP = 2'd1,
        CMD_XLATE = 2'd2
    } tlpt_cmd_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_REJECT   = 3'd1,
        STATUS_NO_TABLE = 3'd2,
        STATUS_CONFLICT = 3'd3,
        STATUS_UNMAPPED = 3'd4
    } tlpt_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_ALLOC,
        ST_TBL_RD,
        ST_TBL_CHK,
        ST_RESP
    } tlpt_state_t;

endpackage

@@ hdl/tlpt_store.sv @@
module tlpt_store #(
    parameter int NUM_TABLES = tlpt_pkg::NUM_TABLES_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 dir_we,
    input  logic [tlpt_pkg::IDX_W-1:0]           dir_waddr,
    input  logic [((NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1)+1:0] dir_wdata,
    input  logic [tlpt_pkg::IDX_W-1:0]           dir_raddr,
    output logic [((NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1)+1:0] dir_rdata,
    input  logic                                 tbl_we,
    input  logic [$clog2(NUM_TABLES*tlpt_pkg::TBL_ENTRIES)-1:0] tbl_waddr,
    input  logic [tlpt_pkg::ENTRY_W-1:0]         tbl_wdata,
    input  logic [$clog2(NUM_TABLES*tlpt_pkg::TBL_ENTRIES)-1:0] tbl_raddr,
    output logic [tlpt_pkg::ENTRY_W-1:0]         tbl_rdata
);

    localparam int SLOT_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int DIR_W   = SLOT_W + 2;
    localparam int TBL_DEPTH = NUM_TABLES * tlpt_pkg::TBL_ENTRIES;

    logic [DIR_W-1:0]                 dir_mem [0:tlpt_pkg::DIR_ENTRIES-1];
    logic [tlpt_pkg::ENTRY_W-1:0]     tbl_mem [0:TBL_DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        dir_rdata <= dir_mem[dir_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rdata <= tbl_mem[tbl_raddr];
    end

endmodule

@@ hdl/two_level_page_table_manager_core.sv @@
// Steps: a request is accepted in idle while the directory is read; words that read the table
// then go through a table read and check before the response, the rest go straight to the
// response. A map that takes a fresh table slot first sweeps its entries clear through the
// table port and rereads the entry. One request at a time: a new request is taken once the
// previous response is registered, and a held response holds the core. After reset release
// the directory and slot zero are swept clear with req_stall high; cfg writes still land.
module two_level_page_table_manager_core #(
    parameter int NUM_TABLES = tlpt_pkg::NUM_TABLES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_wr_en,
    input  logic [tlpt_pkg::VPN_W-1:0]       cfg_wr_data,

    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [1:0]                       cmd,
    input  logic [tlpt_pkg::ADDR_W-1:0]      virt_addr,
    input  logic [tlpt_pkg::ADDR_W-1:0]      phys_addr,
    input  logic [tlpt_pkg::OFFSET_W-1:0]    page_flags,

    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [2:0]                       status,
    output logic [tlpt_pkg::ADDR_W-1:0]      phys_result
);

    localparam int SLOT_W = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int DIR_W  = SLOT_W + 2;
    localparam int TBL_AW = $clog2(NUM_TABLES * tlpt_pkg::TBL_ENTRIES);
    localparam int NFS_W  = $clog2(NUM_TABLES + 1);
    localparam int IDX_W  = tlpt_pkg::IDX_W;
    localparam int OFS_W  = tlpt_pkg::OFFSET_W;
    localparam int AW     = tlpt_pkg::ADDR_W;
    localparam int FRM_W  = AW - OFS_W;

    localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(tlpt_pkg::TBL_ENTRIES - 1);
    localparam logic [NFS_W-1:0] NFS_LIMIT = NFS_W'(NUM_TABLES);

    tlpt_pkg::tlpt_state_t state_reg, state_next;

    logic [tlpt_pkg::VPN_W-1:0] rsv_reg;
    logic [NFS_W-1:0]           nfs_reg, nfs_next;
    logic [IDX_W-1:0]           cnt_reg, cnt_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    logic [1:0]                 cmd_reg;
    logic [AW-1:0]              va_reg;
    logic [AW-1:0]              pa_reg;
    logic [OFS_W-1:0]           flags_reg;
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic [2:0]                 res_status_reg, res_status_next;
    logic [AW-1:0]              res_phys_reg, res_phys_next;
    logic [2:0]                 status_reg;
    logic [AW-1:0]              phys_result_reg;

    logic                       dir_we;
    logic [IDX_W-1:0]           dir_waddr;
    logic [DIR_W-1:0]           dir_wdata;
    logic [IDX_W-1:0]           dir_raddr;
    logic [DIR_W-1:0]           dir_rdata;
    logic                       tbl_we;
    logic [TBL_AW-1:0]          tbl_waddr;
    logic [tlpt_pkg::ENTRY_W-1:0] tbl_wdata;
    logic [TBL_AW-1:0]          tbl_raddr;
    logic [tlpt_pkg::ENTRY_W-1:0] tbl_rdata;

    logic                       accept;
    logic                       rsp_load;
    logic                       dir_present;
    logic                       dir_user;
    logic [SLOT_W-1:0]          dir_slot;
    logic                       req_user;
    logic                       map_bad;
    logic                       is_reserved;
    logic                       nfs_full;
    logic [SLOT_W+IDX_W-1:0]    ent_dir_full;
    logic [SLOT_W+IDX_W-1:0]    ent_slot_full;
    logic [SLOT_W+IDX_W-1:0]    sweep_full;
    logic [SLOT_W+IDX_W-1:0]    clear_full;
    logic                       tbl_present;
    logic                       tbl_match;

    tlpt_store #(
        .NUM_TABLES (NUM_TABLES)
    ) u_store (
        .clk       (clk),
        .dir_we    (dir_we),
        .dir_waddr (dir_waddr),
        .dir_wdata (dir_wdata),
        .dir_raddr (dir_raddr),
        .dir_rdata (dir_rdata),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata)
    );

    assign req_stall   = (state_reg != tlpt_pkg::ST_IDLE);
    assign accept      = req_valid && (state_reg == tlpt_pkg::ST_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign phys_result = phys_result_reg;
    assign rsp_load    = (state_reg == tlpt_pkg::ST_RESP) && (!rsp_valid_reg || !rsp_stall);

    assign dir_present = dir_rdata[SLOT_W+1];
    assign dir_user    = dir_rdata[SLOT_W];
    assign dir_slot    = dir_rdata[SLOT_W-1:0];
    assign req_user    = flags_reg[tlpt_pkg::FLAG_USER_BIT];
    assign is_reserved = (va_reg[AW-1:OFS_W] == rsv_reg);
    assign map_bad     = (va_reg[OFS_W-1:0] != '0) || (pa_reg[OFS_W-1:0] != '0) || is_reserved;
    assign nfs_full    = (nfs_reg >= NFS_LIMIT);

    assign ent_dir_full  = {dir_slot, va_reg[OFS_W+IDX_W-1:OFS_W]};
    assign ent_slot_full = {slot_reg, va_reg[OFS_W+IDX_W-1:OFS_W]};
    assign sweep_full    = {slot_reg, cnt_reg};
    assign clear_full    = {{SLOT_W{1'b0}}, cnt_reg};

    assign tbl_present = tbl_rdata[tlpt_pkg::FLAG_PRESENT_BIT];
    assign tbl_match   = (tbl_rdata[AW-1:OFS_W] == pa_reg[AW-1:OFS_W]) &&
                         (tbl_rdata[OFS_W-1:0] == flags_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlpt_pkg::ST_CLEAR:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = tlpt_pkg::ST_IDLE;
                end
            end
            tlpt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = tlpt_pkg::ST_DECIDE;
                end
            end
            tlpt_pkg::ST_DECIDE:
            begin
                state_next = tlpt_pkg::ST_RESP;
                if (cmd_reg == tlpt_pkg::CMD_MAP && !map_bad)
                begin
                    if (dir_present)
                    begin
                        state_next = tlpt_pkg::ST_TBL_CHK;
                    end
                    else if (!nfs_full)
                    begin
                        state_next = tlpt_pkg::ST_ALLOC;
                    end
                end
                else if (cmd_reg == tlpt_pkg::CMD_XLATE && dir_present)
                begin
                    state_next = tlpt_pkg::ST_TBL_CHK;
                end
            end
            tlpt_pkg::ST_ALLOC:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = tlpt_pkg::ST_TBL_RD;
                end
            end
            tlpt_pkg::ST_TBL_RD:
            begin
                state_next = tlpt_pkg::ST_TBL_CHK;
            end
            tlpt_pkg::ST_TBL_CHK:
            begin
                state_next = tlpt_pkg::ST_RESP;
            end
            tlpt_pkg::ST_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = tlpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlpt_pkg::ST_CLEAR;
            end
        endcase
    end

    // memory controls and datapath
    always_comb
    begin
        dir_we          = 1'b0;
        dir_waddr       = va_reg[AW-1:AW-IDX_W];
        dir_wdata       = '0;
        dir_raddr       = (state_reg == tlpt_pkg::ST_IDLE) ? virt_addr[AW-1:AW-IDX_W]
                                                         : va_reg[AW-1:AW-IDX_W];
        tbl_we          = 1'b0;
        tbl_waddr       = ent_slot_full[TBL_AW-1:0];
        tbl_wdata       = '0;
        tbl_raddr       = (state_reg == tlpt_pkg::ST_DECIDE) ? ent_dir_full[TBL_AW-1:0]
                                                           : ent_slot_full[TBL_AW-1:0];
        nfs_next        = nfs_reg;
        cnt_next        = cnt_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_phys_next   = res_phys_reg;

        case (state_reg)
            tlpt_pkg::ST_CLEAR:
            begin
                // entry zero of the directory points at slot zero
                dir_we    = 1'b1;
                dir_waddr = cnt_reg;
                dir_wdata = (cnt_reg == '0) ? {1'b1, 1'b0, {SLOT_W{1'b0}}} : '0;
                tbl_we    = 1'b1;
                tbl_waddr = clear_full[TBL_AW-1:0];
                cnt_next  = cnt_reg + 1'b1;
            end
            tlpt_pkg::ST_DECIDE:
            begin
                res_status_next = tlpt_pkg::STATUS_OK;
                res_phys_next   = '0;
                case (cmd_reg)
                    tlpt_pkg::CMD_MAP:
                    begin
                        if (map_bad)
                        begin
                            res_status_next = tlpt_pkg::STATUS_REJECT;
                        end
                        else if (!dir_present)
                        begin
                            if (nfs_full)
                            begin
                                res_status_next = tlpt_pkg::STATUS_NO_TABLE;
                            end
                            else
                            begin
                                dir_we    = 1'b1;
                                dir_wdata = {1'b1, req_user, nfs_reg[SLOT_W-1:0]};
                                slot_next = nfs_reg[SLOT_W-1:0];
                                nfs_next  = nfs_reg + 1'b1;
                                cnt_next  = '0;
                            end
                        end
                        else
                        begin
                            // raise user even when the map later conflicts
                            dir_we    = req_user;
                            dir_wdata = {1'b1, dir_user | req_user, dir_slot};
                            slot_next = dir_slot;
                        end
                    end
                    tlpt_pkg::CMD_UNMAP:
                    begin
                        if (is_reserved)
                        begin
                            res_status_next = tlpt_pkg::STATUS_REJECT;
                        end
                        else if (dir_present)
                        begin
                            tbl_we    = 1'b1;
                            tbl_waddr = ent_dir_full[TBL_AW-1:0];
                        end
                    end
                    tlpt_pkg::CMD_XLATE:
                    begin
                        slot_next = dir_slot;
                        if (!dir_present)
                        begin
                            res_status_next = tlpt_pkg::STATUS_UNMAPPED;
                            res_phys_next   = '1;
                        end
                    end
                    default:
                    begin
                        res_status_next = tlpt_pkg::STATUS_REJECT;
                    end
                endcase
            end
            tlpt_pkg::ST_ALLOC:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = sweep_full[TBL_AW-1:0];
                cnt_next  = cnt_reg + 1'b1;
            end
            tlpt_pkg::ST_TBL_CHK:
            begin
                if (cmd_reg == tlpt_pkg::CMD_MAP)
                begin
                    if (tbl_present)
                    begin
                        res_status_next = tbl_match ? tlpt_pkg::STATUS_OK
                                                    : tlpt_pkg::STATUS_CONFLICT;
                    end
                    else
                    begin
                        tbl_we    = 1'b1;
                        tbl_wdata = {pa_reg[AW-1:OFS_W], flags_reg};
                        tbl_wdata[tlpt_pkg::FLAG_PRESENT_BIT] = 1'b1;
                        res_status_next = tlpt_pkg::STATUS_OK;
                    end
                    res_phys_next = '0;
                end
                else if (tbl_present)
                begin
                    res_status_next = tlpt_pkg::STATUS_OK;
                    res_phys_next   = {tbl_rdata[AW-1:OFS_W], va_reg[OFS_W-1:0]};
                end
                else
                begin
                    res_status_next = tlpt_pkg::STATUS_UNMAPPED;
                    res_phys_next   = '1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlpt_pkg::ST_CLEAR;
            rsv_reg       <= tlpt_pkg::RESERVED_RESET;
            nfs_reg       <= NFS_W'(1);
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nfs_reg       <= nfs_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                rsv_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            va_reg    <= virt_addr;
            pa_reg    <= phys_addr;
            flags_reg <= page_flags;
        end
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_phys_reg   <= res_phys_next;
        if (rsp_load)
        begin
            status_reg      <= res_status_reg;
            phys_result_reg <= res_phys_reg;
        end
    end

endmodule

@@ dv/two_level_page_table_manager_core_tb.sv @@
module two_level_page_table_manager_core_tb;

    localparam int NUM_TABLES = 16;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int DIR_POOL = 20;
    localparam int PHASE_WORDS = 240;
    localparam int PHASES = 6;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 6000;

    typedef struct packed {
        logic [1:0]                    op;
        logic [tlpt_pkg::ADDR_W-1:0]   va;
        logic [tlpt_pkg::ADDR_W-1:0]   pa;
        logic [tlpt_pkg::OFFSET_W-1:0] flags;
    } page_req_t;

    typedef struct packed {
        logic [2:0]                  status;
        logic [tlpt_pkg::ADDR_W-1:0] phys;
    } page_rsp_t;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [tlpt_pkg::VPN_W-1:0]    cfg_wr_data = '0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    logic [1:0]                    cmd = tlpt_pkg::CMD_XLATE;
    logic [tlpt_pkg::ADDR_W-1:0]   virt_addr = '0;
    logic [tlpt_pkg::ADDR_W-1:0]   phys_addr = '0;
    logic [tlpt_pkg::OFFSET_W-1:0] page_flags = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    logic [2:0]                    status;
    logic [tlpt_pkg::ADDR_W-1:0]   phys_result;

    // page table shadow
    bit                            dir_present [tlpt_pkg::DIR_ENTRIES];
    bit                            dir_user [tlpt_pkg::DIR_ENTRIES];
    int unsigned                   dir_slot [tlpt_pkg::DIR_ENTRIES];
    bit [tlpt_pkg::ENTRY_W-1:0]    table_mem [NUM_TABLES*tlpt_pkg::TBL_ENTRIES];
    int unsigned                   free_slot;
    logic [tlpt_pkg::VPN_W-1:0]    resv_vpn;

    page_req_t                     request_backlog [$];
    page_rsp_t                     outstanding_replies [$];
    page_req_t                     recent_maps [$];
    logic [tlpt_pkg::IDX_W-1:0]    dir_pool [DIR_POOL];

    int unsigned         send_idle_pct = 0;
    int unsigned         stall_pct = 0;
    int unsigned         hold_asked = 0;
    int unsigned         hold_served = 0;
    int unsigned         hold_left = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         err_count = 0;

    two_level_page_table_manager_core #(
        .NUM_TABLES (NUM_TABLES)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .cmd         (cmd),
        .virt_addr   (virt_addr),
        .phys_addr   (phys_addr),
        .page_flags  (page_flags),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .phys_result (phys_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic page_rsp_t page_table_step(input page_req_t r);
        page_rsp_t                  o;
        logic [tlpt_pkg::IDX_W-1:0] di;
        int unsigned                idx;
        logic [tlpt_pkg::ENTRY_W-1:0] cur;
        o.status = tlpt_pkg::STATUS_OK;
        o.phys = '0;
        di = r.va[31:22];
        case (r.op)
            tlpt_pkg::CMD_MAP:
            begin
                if (r.va[tlpt_pkg::OFFSET_W-1:0] != '0 || r.pa[tlpt_pkg::OFFSET_W-1:0] != '0 ||
                    r.va[31:12] == resv_vpn)
                    o.status = tlpt_pkg::STATUS_REJECT;
                else if (!dir_present[di] && free_slot >= NUM_TABLES)
                    o.status = tlpt_pkg::STATUS_NO_TABLE;
                else
                begin
                    if (!dir_present[di])
                    begin
                        for (int i = 0; i < tlpt_pkg::TBL_ENTRIES; i++)
                            table_mem[free_slot*tlpt_pkg::TBL_ENTRIES + i] = '0;
                        dir_present[di] = 1'b1;
                        dir_slot[di] = free_slot;
                        dir_user[di] = r.flags[tlpt_pkg::FLAG_USER_BIT];
                        free_slot++;
                    end
                    else if (r.flags[tlpt_pkg::FLAG_USER_BIT])
                        dir_user[di] = 1'b1;
                    idx = dir_slot[di]*tlpt_pkg::TBL_ENTRIES + r.va[21:12];
                    cur = table_mem[idx];
                    // an existing entry must match frame and all twelve low bits
                    if (cur[tlpt_pkg::FLAG_PRESENT_BIT])
                    begin
                        if (cur != {r.pa[31:12], r.flags})
                            o.status = tlpt_pkg::STATUS_CONFLICT;
                    end
                    else
                        table_mem[idx] = {r.pa[31:12], r.flags | 12'h001};
                end
            end
            tlpt_pkg::CMD_UNMAP:
            begin
                if (r.va[31:12] == resv_vpn)
                    o.status = tlpt_pkg::STATUS_REJECT;
                else if (dir_present[di])
                    table_mem[dir_slot[di]*tlpt_pkg::TBL_ENTRIES + r.va[21:12]] = '0;
            end
            tlpt_pkg::CMD_XLATE:
            begin
                o.phys = '1;
                o.status = tlpt_pkg::STATUS_UNMAPPED;
                if (dir_present[di])
                begin
                    cur = table_mem[dir_slot[di]*tlpt_pkg::TBL_ENTRIES + r.va[21:12]];
                    if (cur[tlpt_pkg::FLAG_PRESENT_BIT])
                    begin
                        o.status = tlpt_pkg::STATUS_OK;
                        o.phys = {cur[31:12], r.va[tlpt_pkg::OFFSET_W-1:0]};
                    end
                end
            end
            default:
                o.status = tlpt_pkg::STATUS_REJECT;
        endcase
        return o;
    endfunction

    function automatic page_req_t random_request();
        page_req_t   r;
        int unsigned pick;
        pick = $urandom_range(99);
        r.op = tlpt_pkg::CMD_MAP;
        r.va = {dir_pool[$urandom_range(DIR_POOL-1)],
                ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(15)),
                12'h000};
        r.pa = {20'($urandom), 12'h000};
        r.flags = 12'($urandom);
        if (pick < 15 && recent_maps.size() != 0)
        begin
            // repeat a recent mapping, now and then with one flag flipped
            r = recent_maps[$urandom_range(recent_maps.size()-1)];
            if ($urandom_range(3) == 0)
                r.flags ^= 12'(1 << $urandom_range(tlpt_pkg::OFFSET_W-1));
        end
        else if (pick < 45)
        begin
            recent_maps.push_back(r);
            if (recent_maps.size() > 32)
                void'(recent_maps.pop_front());
        end
        else if (pick < 75)
        begin
            r.op = tlpt_pkg::CMD_XLATE;
            r.va[tlpt_pkg::OFFSET_W-1:0] = 12'($urandom);
        end
        else if (pick < 90)
        begin
            r.op = tlpt_pkg::CMD_UNMAP;
            r.va[tlpt_pkg::OFFSET_W-1:0] = 12'($urandom);
        end
        else
        begin
            case ($urandom_range(3))
                0:
                begin
                    r.op = CMD_UNKNOWN;
                    r.va = $urandom;
                end
                1:
                begin
                    r.va = $urandom;
                    r.pa = $urandom;
                end
                2:
                begin
                    r.op = 2'($urandom);
                    r.va = {resv_vpn, 12'($urandom)};
                end
                default:
                begin
                    r.op = 2'($urandom);
                    r.va = $urandom;
                end
            endcase
        end
        return r;
    endfunction

    task automatic push_req(input logic [1:0] op, input logic [tlpt_pkg::ADDR_W-1:0] va,
                            input logic [tlpt_pkg::ADDR_W-1:0] pa,
                            input logic [tlpt_pkg::OFFSET_W-1:0] flags);
        page_req_t r;
        r.op = op;
        r.va = va;
        r.pa = pa;
        r.flags = flags;
        request_backlog.push_back(r);
    endtask

    task automatic wait_all_replied();
        do @(negedge clk);
        while (request_backlog.size() != 0 || req_valid || outstanding_replies.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reserved(input logic [tlpt_pkg::VPN_W-1:0] vpn);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= vpn;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        resv_vpn = vpn;
        @(negedge clk);
    endtask

    // request side: hold a stalled word, advance on accept
    always @(posedge clk)
    begin : drive_req
        page_req_t acc;
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
            begin
                acc.op = cmd;
                acc.va = virt_addr;
                acc.pa = phys_addr;
                acc.flags = page_flags;
                outstanding_replies.push_back(page_table_step(acc));
            end
            if (!req_valid || !req_stall)
            begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    acc = request_backlog.pop_front();
                    req_valid <= 1'b1;
                    cmd <= acc.op;
                    virt_addr <= acc.va;
                    phys_addr <= acc.pa;
                    page_flags <= acc.flags;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : check_rsp
        page_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (outstanding_replies.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected response word, expected none, actual status %0d result %h",
                         $time, status, phys_result);
            end
            else
            begin
                want = outstanding_replies.pop_front();
                if (status !== want.status)
                begin
                    err_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, status);
                end
                if (phys_result !== want.phys)
                begin
                    err_count++;
                    $display("%0t: phys_result mismatch, expected %h, actual %h",
                             $time, want.phys, phys_result);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : run
        logic [tlpt_pkg::VPN_W-1:0] vpn;
        dir_present[0] = 1'b1;
        dir_slot[0] = 0;
        free_slot = 1;
        resv_vpn = tlpt_pkg::RESERVED_RESET;
        dir_pool[0] = '0;
        dir_pool[1] = '1;
        for (int i = 2; i < DIR_POOL; i++)
            dir_pool[i] = 10'($urandom);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        write_reserved(tlpt_pkg::RESERVED_RESET);

        // directed words
        push_req(tlpt_pkg::CMD_XLATE, 32'h0000_0000, 32'h0, 12'h000);
        push_req(tlpt_pkg::CMD_MAP,   32'h0000_1000, 32'hFFFF_F000, 12'hFFF);
        push_req(tlpt_pkg::CMD_XLATE, 32'h0000_1ABC, 32'h0, 12'h000);
        push_req(tlpt_pkg::CMD_MAP,   32'h0000_1000, 32'hFFFF_F000, 12'hFFF);
        push_req(tlpt_pkg::CMD_MAP,   32'h0000_1000, 32'h1234_5000, 12'hFFF);
        push_req(tlpt_pkg::CMD_MAP,   32'h0000_1000, 32'hFFFF_F000, 12'h7FF);
        push_req(tlpt_pkg::CMD_MAP,   32'h0000_2001, 32'h0000_0000, 12'h001);
        push_req(tlpt_pkg::CMD_MAP,   32'h0000_2000, 32'h0000_0FFF, 12'h001);
        push_req(tlpt_pkg::CMD_MAP,   32'h003F_F000, 32'h0000_0000, 12'h001);
        push_req(tlpt_pkg::CMD_UNMAP, 32'h003F_F123, 32'h0, 12'h000);
        push_req(tlpt_pkg::CMD_MAP,   32'hFFFF_F000, 32'h0000_0000, 12'h000);
        push_req(tlpt_pkg::CMD_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h000);
        push_req(tlpt_pkg::CMD_MAP,   32'hFFC0_0000, 32'hABCD_E000, 12'h004);
        push_req(tlpt_pkg::CMD_UNMAP, 32'hFFFF_F000, 32'h0, 12'h000);
        push_req(tlpt_pkg::CMD_XLATE, 32'hFFFF_F000, 32'h0, 12'h000);
        push_req(tlpt_pkg::CMD_UNMAP, 32'h8000_0000, 32'h0, 12'h000);
        push_req(tlpt_pkg::CMD_XLATE, 32'h8000_0123, 32'h0, 12'h000);
        push_req(CMD_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
        // present bit left clear in the request: a repeat of it conflicts
        push_req(tlpt_pkg::CMD_MAP,   32'h0000_2000, 32'h1234_5000, 12'h002);
        push_req(tlpt_pkg::CMD_MAP,   32'h0000_2000, 32'h1234_5000, 12'h002);
        push_req(tlpt_pkg::CMD_UNMAP, 32'h0000_1000, 32'h0, 12'h000);
        push_req(tlpt_pkg::CMD_XLATE, 32'h0000_1000, 32'h0, 12'h000);
        push_req(tlpt_pkg::CMD_XLATE, 32'hFFC0_0FFF, 32'h0, 12'h000);
        wait_all_replied();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: vpn = '0;
                1: vpn = '1;
                3: vpn = 20'($urandom);
                4: vpn = tlpt_pkg::RESERVED_RESET;
                default: vpn = {dir_pool[$urandom_range(DIR_POOL-1)], 10'($urandom_range(15))};
            endcase
            write_reserved(vpn);
            case (p)
                1:
                begin
                    send_idle_pct = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 75;
                end
                3:
                begin
                    send_idle_pct = 25;
                    stall_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            // long receiver hold while the backlog keeps offering words
            if (p == 4)
                hold_asked++;
            for (int i = 0; i < PHASE_WORDS; i++)
                request_backlog.push_back(random_request());
            wait_all_replied();
        end

        repeat (12) @(negedge clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
hdl/tlpt_pkg.sv
hdl/tlpt_store.sv
hdl/two_level_page_table_manager_core.sv
dv/two_level_page_table_manager_core_tb.sv
